// File: rtl/scti_pkg.sv
// constants, types and sine table for the sine/cosine table interpolator
`default_nettype none
package scti_pkg;

  localparam int TABLE_BITS = 8;
  localparam int TABLE_ENTRIES = 1 << TABLE_BITS;
  localparam int FRACTION_BITS = 16;
  localparam int ANGLE_W = 32;
  localparam int TRIG_W = 16;
  localparam int TURN_FRAC_BITS = 48;
  localparam int SCALE_W = 30;
  localparam logic [SCALE_W-1:0] TURN_SCALE = 30'd683565276;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int DIFF_W = TRIG_W + 1;
  localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
  localparam int STAGES = 5;

  // taylor term divisors (2k)(2k+1)
  localparam longint unsigned TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic signed [TRIG_W-1:0] rom_t [0:TABLE_ENTRIES];

  function automatic logic signed [TRIG_W-1:0] rom_value(input int unsigned i);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    logic neg;
    a = (64'd2 * PI_Q30 * longint'(i)) / TABLE_ENTRIES;
    neg = 1'b0;
    if (a > PI_Q30) begin
      a = a - PI_Q30;
      neg = 1'b1;
    end
    if (2 * a > PI_Q30) begin
      a = PI_Q30 - a;
    end
    x2 = (a * a) >> 30;
    term = a;
    sum = a;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd16384) >> 15;
    if (neg) begin
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      return TRIG_W'(-longint'(v));
    end
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return TRIG_W'(v);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      r[i] = rom_value(i);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage
`default_nettype wire

// File: rtl/sin_cos_table_interpolator_top.sv
// sine and cosine of a q16.16 angle by table lookup with linear interpolation
// throughput: one word per cycle while out_stall is low; each stage holds only while its successor is full
// stages: register angle, turn multiply, table read, interpolation multiply, add and saturate
// reset: synchronous, clears all stage valid bits; the table is constant
`default_nettype none
module sin_cos_table_interpolator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [scti_pkg::ANGLE_W-1:0] angle_rad,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [scti_pkg::TRIG_W-1:0] cosine,
  output logic signed [scti_pkg::TRIG_W-1:0] sine
);

  localparam int TB = scti_pkg::TABLE_BITS;
  localparam int FB = scti_pkg::FRACTION_BITS;
  localparam int TW = scti_pkg::TRIG_W;
  localparam int DW = scti_pkg::DIFF_W;
  localparam int PW = scti_pkg::PROD_W;
  localparam int NS = scti_pkg::STAGES;
  localparam int FRW = scti_pkg::TURN_FRAC_BITS;
  localparam int MW = scti_pkg::ANGLE_W + scti_pkg::SCALE_W + 1;

  logic [NS-1:0] valid;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !valid[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];
  assign out_valid = valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
    end
  end

  // stage 1: angle
  logic signed [scti_pkg::ANGLE_W-1:0] ang1;
  always_ff @(posedge clk) begin
    if (en[0]) ang1 <= angle_rad;
  end

  // stage 2: fraction of a turn
  logic signed [MW-1:0] turn_prod;
  logic [FRW-1:0] frac2;
  assign turn_prod = MW'(ang1) * MW'($signed({1'b0, scti_pkg::TURN_SCALE}));
  always_ff @(posedge clk) begin
    if (en[1]) frac2 <= turn_prod[FRW-1:0];
  end

  // stage 3: table read
  logic [TB-1:0] idx_s;
  logic [TB-1:0] idx_c;
  logic [FB-1:0] f_w;
  logic signed [TW-1:0] sa_w, sb_w, ca_w, cb_w;
  assign idx_s = frac2[FRW-1 -: TB];
  assign idx_c = idx_s + TB'(scti_pkg::TABLE_ENTRIES / 4);
  assign f_w = frac2[FRW-1-TB -: FB];
  assign sa_w = scti_pkg::SINE_ROM[{1'b0, idx_s}];
  assign sb_w = scti_pkg::SINE_ROM[{1'b0, idx_s} + (TB+1)'(1)];
  assign ca_w = scti_pkg::SINE_ROM[{1'b0, idx_c}];
  assign cb_w = scti_pkg::SINE_ROM[{1'b0, idx_c} + (TB+1)'(1)];

  logic signed [TW-1:0] sa3, ca3;
  logic signed [DW-1:0] sd3, cd3;
  logic [FB-1:0] f3;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sa3 <= sa_w;
      ca3 <= ca_w;
      sd3 <= DW'(sb_w) - DW'(sa_w);
      cd3 <= DW'(cb_w) - DW'(ca_w);
      f3 <= f_w;
    end
  end

  // stage 4: slope times fraction
  logic signed [TW-1:0] sa4, ca4;
  logic signed [PW-1:0] sp4, cp4;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sa4 <= sa3;
      ca4 <= ca3;
      sp4 <= PW'(sd3) * PW'($signed({1'b0, f3}));
      cp4 <= PW'(cd3) * PW'($signed({1'b0, f3}));
    end
  end

  // stage 5: add with floor and saturate
  function automatic logic signed [TW-1:0] finish(input logic signed [TW-1:0] a,
                                                  input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    logic signed [PW:0] r;
    q = p >>> FB;
    r = (PW+1)'(a) + (PW+1)'(q);
    if (r > (PW+1)'(32767)) begin
      return TW'(32767);
    end
    if (r < -(PW+1)'(32768)) begin
      return TW'(-32768);
    end
    return TW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sine <= finish(sa4, sp4);
      cosine <= finish(ca4, cp4);
    end
  end

  a_reset_clears : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ($countones(valid) == NS) && out_stall)
    else $error("input stalled with a hole in the pipeline");
  a_hold_word : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sine) && $stable(cosine))
    else $error("stalled output word lost");
  a_no_hole_stall : assert property (@(posedge clk) disable iff (rst)
    !valid[0] |-> !in_stall)
    else $error("empty first stage stalls input");

endmodule
`default_nettype wire

// File: verif/sin_cos_table_interpolator_top_test.sv
// testbench for the sine/cosine table interpolator: queued driver, monitor, predicted results
`default_nettype none
module sin_cos_table_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 830;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] TURN_MULT = 64'd683565276;

  typedef struct packed {
    logic signed [scti_pkg::TRIG_W-1:0] cosine;
    logic signed [scti_pkg::TRIG_W-1:0] sine;
  } trig_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [scti_pkg::ANGLE_W-1:0] angle_rad;
  logic out_valid;
  logic out_stall;
  logic signed [scti_pkg::TRIG_W-1:0] cosine;
  logic signed [scti_pkg::TRIG_W-1:0] sine;

  sin_cos_table_interpolator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .angle_rad(angle_rad),
    .out_valid(out_valid), .out_stall(out_stall), .cosine(cosine), .sine(sine)
  );

  logic signed [31:0] sine_table [0:scti_pkg::TABLE_ENTRIES];
  logic [scti_pkg::ANGLE_W-1:0] angle_q[$];
  trig_t trig_q[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  logic in_taken;
  longint unsigned cycles;

  function automatic logic signed [31:0] table_entry(input int i);
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    bit neg;
    a = (64'd2 * scti_pkg::PI_Q30 * i) / scti_pkg::TABLE_ENTRIES;
    neg = 0;
    if (a > scti_pkg::PI_Q30) begin
      a = a - scti_pkg::PI_Q30;
      neg = 1;
    end
    if (2 * a > scti_pkg::PI_Q30) begin
      a = scti_pkg::PI_Q30 - a;
    end
    x2 = (a * a) >> 30;
    term = a;
    sum = a;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd16384) >> 15;
    if (neg) begin
      if (v > 64'd32768) v = 64'd32768;
      return -$signed(32'(v));
    end
    if (v > 64'd32767) v = 64'd32767;
    return $signed(32'(v));
  endfunction

  function automatic logic signed [scti_pkg::TRIG_W-1:0] lerp(input int idx, input longint f);
    longint a;
    longint p;
    longint q;
    longint r;
    a = sine_table[idx];
    p = (longint'(sine_table[idx + 1]) - a) * f;
    q = p >>> scti_pkg::FRACTION_BITS;
    r = a + q;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return scti_pkg::TRIG_W'(r);
  endfunction

  function automatic trig_t predict_trig(input logic [scti_pkg::ANGLE_W-1:0] ang);
    logic [63:0] frac;
    logic [63:0] scaled;
    int idx_s;
    int idx_c;
    longint f;
    trig_t t;
    frac = ({{32{ang[31]}}, ang} * TURN_MULT) & ((64'd1 << 48) - 1);
    scaled = frac * scti_pkg::TABLE_ENTRIES;
    idx_s = int'(scaled >> 48) % scti_pkg::TABLE_ENTRIES;
    f = longint'((scaled & ((64'd1 << 48) - 1)) >> (48 - scti_pkg::FRACTION_BITS));
    idx_c = (idx_s + scti_pkg::TABLE_ENTRIES / 4) % scti_pkg::TABLE_ENTRIES;
    t.sine = lerp(idx_s, f);
    t.cosine = lerp(idx_c, f);
    return t;
  endfunction

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (angle_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        angle_rad <= angle_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) trig_q.push_back(predict_trig(angle_rad));
  end

  // monitor
  always @(posedge clk) begin
    trig_t expd;
    if (!rst && out_valid && !out_stall) begin
      if (trig_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word cos=%0d sin=%0d", cosine, sine);
      end else begin
        expd = trig_q.pop_front();
        if (cosine !== expd.cosine || sine !== expd.sine) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cos exp %0d got %0d, sin exp %0d got %0d",
                     expd.cosine, cosine, expd.sine, sine);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (angle_q.size() > 0 || in_valid || trig_q.size() > 0) @(posedge clk);
  endtask

  task automatic push_random(input int n);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: a = $urandom;
        1: a = $urandom_range(411774) - 205887;
        2: a = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        default: a = 32'(($urandom_range(scti_pkg::TABLE_ENTRIES - 1) * 411775) /
                         scti_pkg::TABLE_ENTRIES);
      endcase
      angle_q.push_back(a);
    end
  endtask

  initial begin
    int phase_pct [4][2];
    phase_pct = '{'{0, 0}, '{76, 0}, '{0, 76}, '{19, 19}};
    for (int i = 0; i <= scti_pkg::TABLE_ENTRIES; i++) sine_table[i] = table_entry(i);
    mismatches = 0;
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    angle_rad = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    angle_q.push_back(32'h0000_0000);
    angle_q.push_back(32'h7FFF_FFFF);
    angle_q.push_back(32'h8000_0000);
    angle_q.push_back(32'hFFFF_FFFF);
    angle_q.push_back(32'h0000_0001);
    angle_q.push_back(32'h0001_921F);
    angle_q.push_back(32'hFFFE_6DE1);
    angle_q.push_back(32'h0003_243F);
    angle_q.push_back(32'h0006_487F);
    angle_q.push_back(32'hFFF9_B781);
    angle_q.push_back(32'h0004_B65F);
    angle_q.push_back(32'h0000_C90F);
    angle_q.push_back(32'h5555_5555);
    angle_q.push_back(32'hAAAA_AAAA);
    angle_q.push_back(32'h0000_0648);
    angle_q.push_back(32'h0003_2440);
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      push_random(N_RANDOM / 5);
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 60;
    push_random(N_RANDOM - 4 * (N_RANDOM / 5));
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && trig_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
